// ===== rtl/lpps_pkg.sv =====
package lpps_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int COUNT_WIDTH    = 16;
  localparam int GRB_WIDTH      = 24;
  localparam int IDX_WIDTH      = $clog2(BITS_PER_PIXEL);
  localparam int REG_WIDTH      = 16;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
  localparam int WORD_WIDTH     = 32;
  localparam int OUT_DATA_WIDTH = 8;

  localparam logic [REG_WIDTH-1:0] PERIOD_RST    = REG_WIDTH'(195);
  localparam logic [REG_WIDTH-1:0] ONE_HIGH_RST  = REG_WIDTH'(98);
  localparam logic [REG_WIDTH-1:0] ZERO_HIGH_RST = REG_WIDTH'(27);

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_PERIOD    = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_ZERO_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [GRB_WIDTH-1:0] grb;
  } tick_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] period;
    logic [REG_WIDTH-1:0] one_high;
    logic [REG_WIDTH-1:0] zero_high;
  } timing_t;

  // floor(p / 255) for p <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== rtl/lpps_front.sv =====
module lpps_front
  import lpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pixel_valid,
  input  logic [WORD_WIDTH-1:0] in_pixel_word,
  output logic                  push_valid,
  output tick_t                 push_tick,
  input  q_status_t             q_status
);

  logic        s_v_r, s_v_nxt;
  logic        s_pv_r;
  logic [15:0] prod_g_r, prod_r_r, prod_b_r;
  logic        load;

  assign in_ready = !s_v_r || !q_status.full;
  assign load     = in_valid && in_ready;

  always_comb begin
    s_v_nxt = s_v_r;
    if (load) begin
      s_v_nxt = 1'b1;
    end else if (s_v_r && !q_status.full) begin
      s_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= s_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_pv_r   <= in_pixel_valid;
      prod_g_r <= 16'(in_pixel_word[23:16]) * 16'(in_pixel_word[31:24]);
      prod_r_r <= 16'(in_pixel_word[15:8])  * 16'(in_pixel_word[31:24]);
      prod_b_r <= 16'(in_pixel_word[7:0])   * 16'(in_pixel_word[31:24]);
    end
  end

  assign push_valid            = s_v_r;
  assign push_tick.pixel_valid = s_pv_r;
  assign push_tick.grb         = {div255(prod_g_r), div255(prod_r_r), div255(prod_b_r)};

endmodule

// ===== rtl/lpps_queue.sv =====
module lpps_queue
  import lpps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  tick_t     push_tick,
  input  logic      pop,
  output tick_t     head_tick,
  output q_status_t status
);

  tick_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_WIDTH:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign status.full  = (cnt_r == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push_valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_tick    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tick;
    end
  end

endmodule

// ===== rtl/lpps_back.sv =====
module lpps_back
  import lpps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [REG_WIDTH-1:0]      cfg_wdata,
  input  tick_t                     head_tick,
  input  q_status_t                 q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      line_level,
  output logic                      pixel_taken,
  output logic                      busy_res
);

  timing_t                  tm_r;
  logic [GRB_WIDTH-1:0]     sw_r, sw_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [IDX_WIDTH-1:0]     idx_r, idx_nxt;
  logic                     sending_r, sending_nxt;
  logic                     ov_r, ov_nxt;
  logic                     lvl_r, taken_r, busy_r;
  logic                     lvl_nxt, taken_nxt, busy_nxt;
  logic                     take;
  logic                     run;
  logic [GRB_WIDTH-1:0]     cur_sw;
  logic [COUNT_WIDTH-1:0]   cur_cnt;
  logic [IDX_WIDTH-1:0]     cur_idx;
  logic [IDX_WIDTH-1:0]     sh;
  logic                     cur_bit;
  logic [REG_WIDTH-1:0]     thr;
  logic                     bit_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_r.period    <= PERIOD_RST;
      tm_r.one_high  <= ONE_HIGH_RST;
      tm_r.zero_high <= ZERO_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PERIOD:    tm_r.period    <= cfg_wdata;
        REG_ONE_HIGH:  tm_r.one_high  <= cfg_wdata;
        REG_ZERO_HIGH: tm_r.zero_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pop = !q_status.empty && (!ov_r || out_ready);

  always_comb begin
    take    = !sending_r && head_tick.pixel_valid;
    run     = sending_r || take;
    cur_sw  = take ? head_tick.grb : sw_r;
    cur_cnt = take ? '0 : cnt_r;
    cur_idx = take ? '0 : idx_r;
    sh      = IDX_WIDTH'(BITS_PER_PIXEL - 1) - cur_idx;
    cur_bit = (32'(sh) < 32'(GRB_WIDTH)) ? cur_sw[sh] : 1'b0;
    thr     = cur_bit ? tm_r.one_high : tm_r.zero_high;
    bit_end = (32'(cur_cnt) >= 32'(tm_r.period)) || (cur_cnt == '1);

    sw_nxt      = cur_sw;
    cnt_nxt     = cur_cnt;
    idx_nxt     = cur_idx;
    sending_nxt = run;
    lvl_nxt     = 1'b0;
    taken_nxt   = take;
    busy_nxt    = run;
    if (run) begin
      lvl_nxt = (32'(cur_cnt) <= 32'(thr));
      if (bit_end) begin
        cnt_nxt = '0;
        if (32'(cur_idx) + 32'd1 >= 32'(BITS_PER_PIXEL)) begin
          idx_nxt     = '0;
          sending_nxt = 1'b0;
        end else begin
          idx_nxt = cur_idx + 1'b1;
        end
      end else begin
        cnt_nxt = cur_cnt + 1'b1;
      end
    end

    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r      <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      sending_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        sw_r      <= sw_nxt;
        cnt_r     <= cnt_nxt;
        idx_r     <= idx_nxt;
        sending_r <= sending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lvl_r   <= lvl_nxt;
      taken_r <= taken_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign line_level  = lvl_r;
  assign pixel_taken = taken_r;
  assign busy_res    = busy_r;

endmodule

// ===== rtl/led_pixel_pulse_serializer_top.sv =====
// One-wire LED pixel serializer with brightness scaling. Every input item is one tick of
// the bit timer and produces exactly one output item (line level, pixel taken, busy), in
// order. A tick offering a pixel (in_tuser high) while idle loads it: green, red and blue
// are scaled by brightness/255, truncated, and the GRB word is sent MSB first, each bit
// lasting period_counts+1 ticks and held high while the tick count is at or below the
// one or zero threshold. One item is taken per clock when the output is not stalled;
// an output item passes the multiply register, then a queue entry, then the output register,
// which is loaded on the same edge as the state update, before it is offered. Configuration
// writes take effect on the next clock; the user must make them while no items are in
// flight, and the block does not enforce this.
module led_pixel_pulse_serializer_top
  import lpps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [WORD_WIDTH-1:0]     in_tdata,   // [31:0] pixel_word
  input  logic                      in_tuser,   // [0] pixel_valid
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,  // [0] line_level, [1] pixel_taken,
                                                // [2] busy_res, [7:3] zero
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [REG_WIDTH-1:0]      cfg_wdata
);

  logic      push_valid;
  tick_t     push_tick;
  tick_t     head_tick;
  q_status_t q_status;
  logic      pop;
  logic      line_level, pixel_taken, busy_res;

  lpps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_pixel_valid (in_tuser),
    .in_pixel_word  (in_tdata),
    .push_valid     (push_valid),
    .push_tick      (push_tick),
    .q_status       (q_status)
  );

  lpps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tick  (push_tick),
    .pop        (pop),
    .head_tick  (head_tick),
    .status     (q_status)
  );

  lpps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .head_tick   (head_tick),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .line_level  (line_level),
    .pixel_taken (pixel_taken),
    .busy_res    (busy_res)
  );

  assign out_tdata = {(OUT_DATA_WIDTH-3)'(0), busy_res, pixel_taken, line_level};

`ifndef SYNTHESIS
  a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !busy_res |-> !line_level)
    else $error("line high on an idle tick");

  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pixel_taken |-> busy_res)
    else $error("pixel taken without starting to send");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sim/tb_led_pixel_pulse_serializer_top.sv =====
module tb_led_pixel_pulse_serializer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpps_pkg::*;

  typedef struct packed {
    logic busy;
    logic taken;
    logic level;
  } pulse_t;

  typedef enum bit {ROW_TICK, ROW_TIMING} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  pv;
    logic [WORD_WIDTH-1:0] word;
    logic [7:0]            reps;
    bit                    typed;
    pulse_t                want;
    logic [REG_WIDTH-1:0]  per;
    logic [REG_WIDTH-1:0]  one_hi;
    logic [REG_WIDTH-1:0]  zero_hi;
  } dir_row_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [WORD_WIDTH-1:0]     in_tdata   = '0;
  logic                      in_tuser   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] out_tdata;
  logic                      cfg_we     = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr   = REG_PERIOD;
  logic [REG_WIDTH-1:0]      cfg_wdata  = '0;

  // serializer model state and timing copy
  logic [GRB_WIDTH-1:0]   grb_sr    = '0;
  logic [COUNT_WIDTH-1:0] tick_pos  = '0;
  logic [4:0]             bit_pos   = '0;
  bit                     tx_active = 1'b0;
  logic [REG_WIDTH-1:0]   per_cfg   = PERIOD_RST;
  logic [REG_WIDTH-1:0]   one_cfg   = ONE_HIGH_RST;
  logic [REG_WIDTH-1:0]   zero_cfg  = ZERO_HIGH_RST;

  pulse_t      pending_pulses[$];
  pulse_t      head_pulse;
  int unsigned errors        = 0;
  int unsigned ticks_sent    = 0;
  int unsigned pulses_seen   = 0;
  int unsigned pixels_loaded = 0;
  int unsigned timings_used  = 0;
  int unsigned burst_left    = 0;

  int unsigned rx_cycle       = 0;
  int unsigned rx_mode        = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  dir_row_t dir_rows [11] = '{
    '{ROW_TICK,   1'b0, 32'h0000_0000, 8'd1, 1'b1, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TICK,   1'b0, 32'hFFFF_FFFF, 8'd1, 1'b1, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TICK,   1'b1, 32'hFFFF_FFFF, 8'd1, 1'b1, 3'b111, 16'd0, 16'd0,    16'd0},
    '{ROW_TICK,   1'b1, 32'h0000_0000, 8'd1, 1'b1, 3'b101, 16'd0, 16'd0,    16'd0},
    '{ROW_TIMING, 1'b0, 32'h0000_0000, 8'd0, 1'b0, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TICK,   1'b1, 32'h00FF_FFFF, 8'd4, 1'b0, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TIMING, 1'b0, 32'h0000_0000, 8'd0, 1'b0, 3'b000, 16'd2, 16'hFFFF, 16'hFFFF},
    '{ROW_TICK,   1'b0, 32'hDEAD_BEEF, 8'd4, 1'b0, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TIMING, 1'b0, 32'h0000_0000, 8'd0, 1'b0, 3'b000, 16'd3, 16'd1,    16'd0},
    '{ROW_TICK,   1'b1, 32'hFF12_3456, 8'd6, 1'b0, 3'b000, 16'd0, 16'd0,    16'd0},
    '{ROW_TICK,   1'b1, 32'h80A5_C3E7, 8'd3, 1'b0, 3'b000, 16'd0, 16'd0,    16'd0}
  };

  led_pixel_pulse_serializer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [7:0] h);
    int unsigned p;
    p = 32'(c) * 32'(h);
    return 8'(p / 255);
  endfunction

  function automatic pulse_t serialize_tick(input logic pv, input logic [WORD_WIDTH-1:0] w);
    pulse_t               r;
    logic [7:0]           hb;
    logic                 bit_val;
    logic [REG_WIDTH-1:0] thr;
    r = '0;
    if (!tx_active && pv) begin
      hb = w[31:24];
      grb_sr = {scale_color(w[23:16], hb), scale_color(w[15:8], hb), scale_color(w[7:0], hb)};
      tick_pos = '0;
      bit_pos = '0;
      tx_active = 1'b1;
      r.taken = 1'b1;
      pixels_loaded++;
    end
    if (tx_active) begin
      bit_val = grb_sr[GRB_WIDTH - 1 - bit_pos];
      thr = bit_val ? one_cfg : zero_cfg;
      r.busy = 1'b1;
      r.level = (tick_pos <= thr);
      if (tick_pos >= per_cfg || tick_pos == '1) begin
        tick_pos = '0;
        if (bit_pos == BITS_PER_PIXEL - 1) begin
          bit_pos = '0;
          tx_active = 1'b0;
        end else begin
          bit_pos++;
        end
      end else begin
        tick_pos++;
      end
    end
    return r;
  endfunction

  task automatic send_tick(input logic pv, input logic [WORD_WIDTH-1:0] w, input bit typed,
                           input pulse_t want);
    pulse_t      got;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= pv;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    got = serialize_tick(pv, w);
    pending_pulses.push_back(typed ? want : got);
    ticks_sent++;
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_timing(input logic [REG_WIDTH-1:0] per, input logic [REG_WIDTH-1:0] one_hi,
                            input logic [REG_WIDTH-1:0] zero_hi);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_addr  <= REG_ONE_HIGH;
    cfg_wdata <= one_hi;
    @(posedge clk);
    cfg_addr  <= REG_ZERO_HIGH;
    cfg_wdata <= zero_hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    per_cfg  = per;
    one_cfg  = one_hi;
    zero_cfg = zero_hi;
    timings_used++;
  endtask

  task automatic run_phase(input logic [REG_WIDTH-1:0] per, input logic [REG_WIDTH-1:0] one_hi,
                           input logic [REG_WIDTH-1:0] zero_hi, input int unsigned n);
    logic [7:0] hb;
    drain_pipeline();
    set_timing(per, one_hi, zero_hi);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       hb = 8'h00;
        1:       hb = 8'hFF;
        default: hb = 8'($urandom);
      endcase
      send_tick($urandom_range(0, 9) != 0, {hb, 24'($urandom)}, 1'b0, '0);
    end
  endtask

  // receiver: changing ready patterns plus one long hold-off
  always @(posedge clk) begin
    rx_cycle++;
    if (!long_hold_done && rx_cycle >= 300 && in_tvalid) begin
      long_hold_done = 1'b1;
      hold_left = 120;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pulses_seen++;
      if (pending_pulses.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, actual %b", $time, out_tdata);
      end else begin
        head_pulse = pending_pulses.pop_front();
        if (out_tdata[0] !== head_pulse.level || out_tdata[1] !== head_pulse.taken ||
            out_tdata[2] !== head_pulse.busy || out_tdata[7:3] !== 5'd0) begin
          errors++;
          $display("%0t: mismatch, expected busy/taken/level %b, actual tdata %b",
                   $time, head_pulse, out_tdata);
        end
      end
    end
  end

  initial begin
    logic [REG_WIDTH-1:0] p;
    logic [REG_WIDTH-1:0] o;
    logic [REG_WIDTH-1:0] z;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_TIMING) begin
        drain_pipeline();
        set_timing(dir_rows[i].per, dir_rows[i].one_hi, dir_rows[i].zero_hi);
      end else begin
        repeat (dir_rows[i].reps)
          send_tick(dir_rows[i].pv, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    run_phase(PERIOD_RST, ONE_HIGH_RST, ZERO_HIGH_RST, 300);
    run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 40);
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 40);
    run_phase(16'd1, 16'd0, 16'd0, 100);
    run_phase(16'd0, 16'hFFFF, 16'd0, 60);
    repeat (9) begin
      p = 16'($urandom_range(0, 6));
      o = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, p + 1));
      z = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, p + 1));
      run_phase(p, o, z, 100);
    end

    drain_pipeline();
    repeat (12) @(posedge clk);
    $display("Sent %0d ticks over %0d timing settings, %0d pixels loaded.",
             ticks_sent, timings_used, pixels_loaded);
    $display("Checked %0d output items, %0d mismatches.", pulses_seen, errors);
    if (errors == 0) begin
      $display("[led_pixel_pulse_serializer_top] OK");
    end else begin
      $display("[led_pixel_pulse_serializer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items still expected.", pending_pulses.size());
    $display("[led_pixel_pulse_serializer_top] ERROR");
    $finish;
  end

endmodule
